@@ hdl/ssr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

  // Register map: four 64-bit registers at byte address 8*i
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;
  localparam int LENW   = 4;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_REPLACE_BYTES  = 2'd2,
    REG_REPLACE_LENGTH = 2'd3
  } reg_index_t;

  // Source of an emitted byte
  typedef enum logic [1:0] {
    SEL_CHAR = 2'd0,
    SEL_PAT  = 2'd1,
    SEL_REP  = 2'd2
  } emit_sel_t;

  // Match depth update
  typedef enum logic [1:0] {
    D_HOLD = 2'd0,
    D_FALL = 2'd1,
    D_INC  = 2'd2,
    D_ZERO = 2'd3
  } d_op_t;

  // Byte counter update
  typedef enum logic [2:0] {
    CNT_HOLD  = 3'd0,
    CNT_CLR   = 3'd1,
    CNT_INC   = 3'd2,
    CNT_FALL  = 3'd3,
    CNT_FLUSH = 3'd4
  } cnt_op_t;

  typedef struct packed {
    logic      load;
    d_op_t     d_op;
    cnt_op_t   cnt_op;
    logic      emit_en;
    emit_sel_t emit_sel;
    logic      fin_en;
  } cmd_t;

  typedef struct packed {
    logic tbl_ready;
    logic len_zero;
    logic d_zero;
    logic pat_hit;
    logic match_done;
    logic rep_zero;
    logic k_last_pat;
    logic k_last_rep;
    logic item_last;
    logic emit_ok;
    logic fin_ok;
  } status_t;

  // Byte i of a 64-bit word, byte 0 in bits 7:0
  function automatic logic [BYTE_W-1:0] byte_of(input logic [DATA_W-1:0] w,
                                                input logic [2:0] i);
    return w[{i, 3'b000} +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

@@ hdl/ssr_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssr_datapath #(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // config port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssr_pkg::DATA_W-1:0] pwdata,
  output logic      [ssr_pkg::DATA_W-1:0] prdata,
  // input word
  input  wire logic [7:0]                 text_byte,
  input  wire logic                       text_last,
  // result word
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output logic      [7:0]                 result_byte,
  output logic                            byte_present,
  output logic                            result_last,
  // controller link
  input  wire ssr_pkg::cmd_t              cmd,
  output ssr_pkg::status_t                st
);
  import ssr_pkg::*;

  localparam int DW   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int MAXL = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
  localparam int KW   = $clog2(MAXL + 1);

  // Config registers
  logic [DATA_W-1:0] pattern_bytes;
  logic [LENW-1:0]   pattern_length;
  logic [DATA_W-1:0] replace_bytes;
  logic [LENW-1:0]   replace_length;

  // Failure table, rebuilt from the pattern registers every cycle
  logic [DW-1:0] tbl      [PATTERN_MAX];
  logic [DW-1:0] tbl_next [PATTERN_MAX];
  logic          tbl_stale;

  // Item and match state
  logic [7:0]    c_reg;
  logic          last_reg;
  logic [DW-1:0] d;
  logic [KW-1:0] k;
  logic [KW-1:0] kend;

  // Hold stage: the newest byte of an item, kept until we know if it is final
  logic          hold_valid;
  logic [7:0]    hold_byte;

  logic [LENW-1:0] pl;
  logic [LENW-1:0] rl;
  logic [DW-1:0]   f_raw;
  logic [DW-1:0]   f_eff;
  logic [7:0]      emit_byte;
  logic            out_free;
  logic            cfg_we;
  logic            pat_we;
  reg_index_t      widx;

  assign widx   = reg_index_t'(paddr[ADDR_W-1:3]);
  assign cfg_we = psel & penable & pwrite;
  assign pat_we = cfg_we & ((widx == REG_PATTERN_BYTES) | (widx == REG_PATTERN_LENGTH));

  // Clamped lengths
  assign pl = (pattern_length > LENW'(PATTERN_MAX)) ? LENW'(PATTERN_MAX) : pattern_length;
  assign rl = (replace_length > LENW'(REPLACE_MAX)) ? LENW'(REPLACE_MAX) : replace_length;

  // Fallback depth for a broken match
  assign f_raw = tbl[d];
  assign f_eff = (f_raw >= d) ? '0 : f_raw;

  assign out_free = ~result_valid | result_ready;

  // Status to controller
  always_comb begin
    st.tbl_ready  = ~tbl_stale;
    st.len_zero   = (pl == '0);
    st.d_zero     = (d == '0);
    st.pat_hit    = (byte_of(pattern_bytes, 3'(d)) == c_reg);
    st.match_done = ((LENW'(d) + LENW'(1)) == pl);
    st.rep_zero   = (rl == '0);
    st.k_last_pat = ((k + KW'(1)) == kend);
    st.k_last_rep = ((LENW'(k) + LENW'(1)) == rl);
    st.item_last  = last_reg;
    st.emit_ok    = ~hold_valid | out_free;
    st.fin_ok     = out_free;
  end

  // Config read
  always_comb begin
    case (widx)
      REG_PATTERN_BYTES:  prdata = pattern_bytes;
      REG_PATTERN_LENGTH: prdata = DATA_W'(pattern_length);
      REG_REPLACE_BYTES:  prdata = replace_bytes;
      REG_REPLACE_LENGTH: prdata = DATA_W'(replace_length);
      default:            prdata = '0;
    endcase
  end

  // Config write
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
      replace_bytes  <= '0;
      replace_length <= '0;
    end else if (cfg_we) begin
      case (widx)
        REG_PATTERN_BYTES:  pattern_bytes  <= pwdata;
        REG_PATTERN_LENGTH: pattern_length <= pwdata[LENW-1:0];
        REG_REPLACE_BYTES:  replace_bytes  <= pwdata;
        REG_REPLACE_LENGTH: replace_length <= pwdata[LENW-1:0];
        default: ;
      endcase
    end
  end

  // Longest proper border of each pattern prefix, entries below pl only
  always_comb begin
    logic hit;
    hit = 1'b0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      tbl_next[j] = '0;
      if (j >= 2 && LENW'(j) < pl) begin
        for (int b = 1; b < j; b++) begin
          hit = 1'b1;
          for (int t = 0; t < b; t++) begin
            hit = hit & (byte_of(pattern_bytes, 3'(t)) ==
                         byte_of(pattern_bytes, 3'(j - b + t)));
          end
          if (hit) tbl_next[j] = DW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < PATTERN_MAX; j++) tbl[j] <= '0;
      tbl_stale <= 1'b0;
    end else begin
      for (int j = 0; j < PATTERN_MAX; j++) tbl[j] <= tbl_next[j];
      tbl_stale <= pat_we;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_reg    <= text_byte;
      last_reg <= text_last;
    end
  end

  // Match depth
  always_ff @(posedge clk) begin
    if (rst) begin
      d <= '0;
    end else if (pat_we) begin
      d <= '0;
    end else if (cmd.load) begin
      if (pl == '0 || LENW'(d) >= pl) d <= '0;
    end else begin
      case (cmd.d_op)
        D_FALL:  d <= f_eff;
        D_INC:   d <= d + DW'(1);
        D_ZERO:  d <= '0;
        default: ;
      endcase
    end
  end

  // Byte counter and its end mark
  always_ff @(posedge clk) begin
    case (cmd.cnt_op)
      CNT_CLR:   k <= '0;
      CNT_INC:   k <= k + KW'(1);
      CNT_FALL: begin
        k    <= '0;
        kend <= KW'(d - f_eff);
      end
      CNT_FLUSH: begin
        k    <= '0;
        kend <= KW'(d);
      end
      default: ;
    endcase
  end

  // Emitted byte select
  always_comb begin
    case (cmd.emit_sel)
      SEL_CHAR: emit_byte = c_reg;
      SEL_PAT:  emit_byte = byte_of(pattern_bytes, 3'(k));
      SEL_REP:  emit_byte = byte_of(replace_bytes, 3'(k));
      default:  emit_byte = c_reg;
    endcase
  end

  // Hold stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // output register: take the held byte or the end marker, else drain
      if (cmd.emit_en && hold_valid) begin
        result_valid <= 1'b1;
        result_byte  <= hold_byte;
        byte_present <= 1'b1;
        result_last  <= 1'b0;
      end else if (cmd.fin_en && hold_valid) begin
        result_valid <= 1'b1;
        result_byte  <= hold_byte;
        byte_present <= 1'b1;
        result_last  <= last_reg;
      end else if (cmd.fin_en && last_reg) begin
        // bare end marker
        result_valid <= 1'b1;
        result_byte  <= '0;
        byte_present <= 1'b0;
        result_last  <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      // hold stage
      if (cmd.emit_en) begin
        hold_valid <= 1'b1;
        hold_byte  <= emit_byte;
      end else if (cmd.fin_en) begin
        hold_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/ssr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             text_valid,
  output logic                  text_ready,
  input  wire ssr_pkg::status_t st,
  output ssr_pkg::cmd_t         cmd
);
  import ssr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_BACK  = 7'b0000100,
    S_CHAR  = 7'b0001000,
    S_REP   = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    text_ready   = 1'b0;
    cmd.load     = 1'b0;
    cmd.d_op     = D_HOLD;
    cmd.cnt_op   = CNT_HOLD;
    cmd.emit_en  = 1'b0;
    cmd.emit_sel = SEL_CHAR;
    cmd.fin_en   = 1'b0;
    case (state)
      // wait for a word, table must be current
      S_IDLE: begin
        text_ready = st.tbl_ready;
        if (text_valid && st.tbl_ready) begin
          cmd.load   = 1'b1;
          state_next = st.len_zero ? S_CHAR : S_SCAN;
        end
      end
      // compare byte against pattern at current depth
      S_SCAN: begin
        if (!st.d_zero && !st.pat_hit) begin
          cmd.d_op   = D_FALL;
          cmd.cnt_op = CNT_FALL;
          state_next = S_BACK;
        end else if (st.pat_hit) begin
          if (st.match_done) begin
            cmd.d_op   = D_ZERO;
            cmd.cnt_op = CNT_CLR;
            state_next = st.rep_zero ? S_DONE : S_REP;
          end else begin
            cmd.d_op   = D_INC;
            state_next = S_DONE;
          end
        end else begin
          state_next = S_CHAR;
        end
      end
      // give back bytes that can no longer start a match
      S_BACK: begin
        if (st.emit_ok) begin
          cmd.emit_en  = 1'b1;
          cmd.emit_sel = SEL_PAT;
          cmd.cnt_op   = CNT_INC;
          if (st.k_last_pat) state_next = S_SCAN;
        end
      end
      S_CHAR: begin
        if (st.emit_ok) begin
          cmd.emit_en  = 1'b1;
          cmd.emit_sel = SEL_CHAR;
          state_next   = S_DONE;
        end
      end
      S_REP: begin
        if (st.emit_ok) begin
          cmd.emit_en  = 1'b1;
          cmd.emit_sel = SEL_REP;
          cmd.cnt_op   = CNT_INC;
          if (st.k_last_rep) state_next = S_DONE;
        end
      end
      // flush held bytes on the last word, then close the item
      S_DONE: begin
        if (st.item_last && !st.d_zero) begin
          cmd.d_op   = D_ZERO;
          cmd.cnt_op = CNT_FLUSH;
          state_next = S_FLUSH;
        end else if (st.fin_ok) begin
          cmd.fin_en = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (st.emit_ok) begin
          cmd.emit_en  = 1'b1;
          cmd.emit_sel = SEL_PAT;
          cmd.cnt_op   = CNT_INC;
          if (st.k_last_pat) state_next = S_DONE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/stream_substring_replace.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Streaming find-and-replace. Text comes in one byte per word; every leftmost,
// non-overlapping occurrence of the pattern (pattern_bytes/pattern_length, up
// to PATTERN_MAX bytes) is replaced by replace_bytes/replace_length, and other
// bytes pass through in order. Pattern length 0 passes text through unchanged.
// Each word is scanned against the pattern, with an extra scan step for each
// failure-table fallback and a flush on the last word; result bytes leave one
// at a time through the single output port, and no new word is taken until the
// current one is done. The last result of a text carries result_last; if the
// last input byte makes no byte, a bare marker with byte_present low is sent.
// Writing the pattern drops any partial match and blocks input while the
// failure table is rebuilt. Registers sit at byte addresses 0, 8, 16 and 24.
module stream_substring_replace #(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssr_pkg::DATA_W-1:0] pwdata,
  output logic      [ssr_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       text_valid,
  output logic                            text_ready,
  input  wire logic [7:0]                 text_byte,
  input  wire logic                       text_last,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output logic      [7:0]                 result_byte,
  output logic                            byte_present,
  output logic                            result_last
);
  import ssr_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign pready = 1'b1;

  ssr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .st         (st),
    .cmd        (cmd)
  );

  ssr_datapath #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .text_byte    (text_byte),
    .text_last    (text_last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_byte  (result_byte),
    .byte_present (byte_present),
    .result_last  (result_last),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_stream_substring_replace.sv @@
`timescale 1ns / 1ps

module tb_stream_substring_replace;
  import ssr_pkg::*;

  localparam int PATTERN_MAX   = 8;
  localparam int REPLACE_MAX   = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_WORDS  = 370;
  localparam int DIR_ROWS      = 33;

  // One word on the result channel
  typedef struct packed {
    logic [7:0] result_byte;
    logic       byte_present;
    logic       result_last;
  } out_word_t;

  typedef enum logic {
    ROW_CFG  = 1'b0,
    ROW_TEXT = 1'b1
  } row_kind_t;

  // Directed stimulus row: a register write or a text word
  typedef struct packed {
    row_kind_t   kind;
    reg_index_t  reg_idx;
    logic [63:0] value;
    logic        text_last;
    logic        typed;
    out_word_t   want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                text_valid   = 1'b0;
  logic                text_ready;
  logic [7:0]          text_byte    = 8'h00;
  logic                text_last    = 1'b0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [7:0]          result_byte;
  logic                byte_present;
  logic                result_last;

  // Predictor state
  logic [63:0] cfg_pattern     = '0;
  logic [3:0]  cfg_pattern_len = '0;
  logic [63:0] cfg_replace     = '0;
  logic [3:0]  cfg_replace_len = '0;
  int unsigned held_depth      = 0;
  int unsigned border_table [PATTERN_MAX];

  out_word_t   step_words [16];
  int unsigned step_count;
  out_word_t   rewrite_q [$];
  out_word_t   head;

  int          error_count  = 0;
  int          random_words = 0;
  logic        steady       = 1'b0;

  // 'a' = 61, 'b' = 62, 'c' = 63, 'X' = 58, 'Y' = 59
  dir_row_t dir_rows [DIR_ROWS] = '{
    // pass-through after reset
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    // pattern "aab" -> "XY"
    '{ROW_CFG,  REG_PATTERN_BYTES,  64'h62_6161, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_PATTERN_LENGTH, 64'd3,       1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_REPLACE_BYTES,  64'h5958,    1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_REPLACE_LENGTH, 64'd2,       1'b0, 1'b0, '0},
    // "aaab": one fallback, then a match
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h61, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h61, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h61, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h62, 1'b0, 1'b0, '0},
    // held byte flushed on last
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h61, 1'b1, 1'b1, '{8'h61, 1'b1, 1'b1}},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h61, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h61, 1'b1, 1'b0, '0},
    // partial match dropped by a pattern write mid-text
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h61, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h61, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_PATTERN_BYTES, 64'h62_6162, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h63, 1'b1, 1'b1, '{8'h63, 1'b1, 1'b1}},
    // deleted match at the last byte leaves a bare end marker
    '{ROW_CFG,  REG_REPLACE_LENGTH, 64'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h62, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h61, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'h62, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
    // oversized lengths clamp to eight bytes
    '{ROW_CFG,  REG_PATTERN_BYTES,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_PATTERN_LENGTH, 64'd15,                  1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_REPLACE_BYTES,  64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_REPLACE_LENGTH, 64'd15,                  1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, '0},
    '{ROW_TEXT, REG_PATTERN_BYTES, 64'hFF, 1'b1, 1'b0, '0}
  };

  stream_substring_replace dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .text_last    (text_last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_byte  (result_byte),
    .byte_present (byte_present),
    .result_last  (result_last)
  );

  always #2 clk = ~clk;

  // ---------------- predictor ----------------

  function automatic logic [7:0] byte_at(input logic [63:0] w, input int unsigned i);
    return w[8 * (i % 8) +: 8];
  endfunction

  function automatic int unsigned pattern_span();
    return (cfg_pattern_len > PATTERN_MAX) ? PATTERN_MAX : cfg_pattern_len;
  endfunction

  function automatic int unsigned replace_span();
    return (cfg_replace_len > REPLACE_MAX) ? REPLACE_MAX : cfg_replace_len;
  endfunction

  // KMP border lengths; entry d belongs to the first d pattern bytes
  function automatic void rebuild_borders();
    int unsigned span;
    int unsigned border;
    int unsigned i;
    logic [7:0]  c;
    span   = pattern_span();
    border = 0;
    for (i = 0; i < PATTERN_MAX; i++) border_table[i] = 0;
    for (i = 1; i + 1 < span; i++) begin
      c = byte_at(cfg_pattern, i);
      while (border > 0 && byte_at(cfg_pattern, border) != c) border = border_table[border];
      if (byte_at(cfg_pattern, border) == c) border++;
      if (i + 1 < PATTERN_MAX) border_table[i + 1] = border;
    end
  endfunction

  function automatic void apply_config(input reg_index_t idx, input logic [63:0] v);
    case (idx)
      REG_PATTERN_BYTES: begin
        cfg_pattern = v;
        held_depth  = 0;
        rebuild_borders();
      end
      REG_PATTERN_LENGTH: begin
        cfg_pattern_len = v[3:0];
        held_depth      = 0;
        rebuild_borders();
      end
      REG_REPLACE_BYTES:  cfg_replace = v;
      REG_REPLACE_LENGTH: cfg_replace_len = v[3:0];
      default: ;
    endcase
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    if (step_count < 16) step_words[step_count] = '{b, 1'b1, 1'b0};
    step_count++;
  endfunction

  // Rewritten words caused by one text word, into step_words/step_count
  function automatic void rewrite_step(input logic [7:0] c, input logic is_last);
    int unsigned span;
    int unsigned d;
    int unsigned f;
    int unsigned k;
    span       = pattern_span();
    d          = held_depth;
    step_count = 0;
    if (span == 0) begin
      emit_byte(c);
      d = 0;
    end else begin
      if (d >= span) d = 0;
      // give back bytes that can no longer start a match
      while (d > 0 && byte_at(cfg_pattern, d) != c) begin
        f = border_table[d % PATTERN_MAX];
        if (f >= d) f = 0;
        for (k = 0; k < d - f; k++) emit_byte(byte_at(cfg_pattern, k));
        d = f;
      end
      if (byte_at(cfg_pattern, d) == c) begin
        d++;
        if (d == span) begin
          for (k = 0; k < replace_span(); k++) emit_byte(byte_at(cfg_replace, k));
          d = 0;
        end
      end else begin
        emit_byte(c);
      end
    end
    // end of text: flush held bytes and mark the final word
    if (is_last) begin
      for (k = 0; k < d; k++) emit_byte(byte_at(cfg_pattern, k));
      d = 0;
      if (step_count == 0) begin
        step_words[0] = '{8'h00, 1'b0, 1'b1};
        step_count    = 1;
      end else begin
        step_words[step_count - 1].result_last = 1'b1;
      end
    end
    held_depth = d;
  endfunction

  // ---------------- drivers ----------------

  // Result side stalls at random except in steady stretches
  always @(negedge clk) begin
    result_ready <= !rst && (steady || $urandom_range(0, 99) >= 18);
  end

  // Entered and left at a falling edge
  task automatic write_register(input reg_index_t idx, input logic [63:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    apply_config(idx, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Send one text word; entered and left at a falling edge
  task automatic send_text_word(input logic [7:0] b, input logic is_last,
                                input logic typed, input out_word_t want);
    int unsigned k;
    while (!steady && $urandom_range(0, 99) < 18) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    text_last  <= is_last;
    do @(posedge clk); while (text_ready !== 1'b1);
    rewrite_step(b, is_last);
    if (typed) begin
      rewrite_q.push_back(want);
    end else begin
      for (k = 0; k < step_count; k++) rewrite_q.push_back(step_words[k]);
    end
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected word, then let the block go quiet
  task automatic settle_block();
    text_valid <= 1'b0;
    while (rewrite_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One random setting followed by a few texts built mostly from the pattern
  task automatic run_random_phase(input int ph);
    logic [63:0] pat;
    logic [63:0] rep;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [7:0]  sym [0:1];
    logic [7:0]  words [$];
    logic        open_end;
    int unsigned span;
    int unsigned texts;
    int unsigned goal;
    int unsigned pick;
    int unsigned cut;
    int unsigned t;
    int unsigned i;
    steady <= (ph == 5 || ph == 6);
    sym[0] = 8'($urandom);
    sym[1] = 8'($urandom);
    pat    = {$urandom, $urandom};
    rep    = {$urandom, $urandom};
    case (ph)
      0:       begin plen = 4'd1;  rlen = 4'd8;  end
      1:       begin plen = 4'd8;  rlen = 4'd0;  end
      2:       begin plen = 4'd0;  rlen = 4'd15; end
      3:       begin plen = 4'd15; rlen = 4'd1;  end
      default: begin
        plen = 4'($urandom_range(0, 15));
        rlen = 4'($urandom_range(0, 15));
      end
    endcase
    span = (plen > PATTERN_MAX) ? PATTERN_MAX : plen;
    // two-symbol alphabet so matches and fallbacks are common
    if ($urandom_range(0, 9) != 0) begin
      for (i = 0; i < span; i++) pat[8 * i +: 8] = sym[$urandom_range(0, 1)];
    end

    settle_block();
    write_register(REG_PATTERN_BYTES, pat);
    write_register(REG_PATTERN_LENGTH, {60'd0, plen});
    write_register(REG_REPLACE_BYTES, rep);
    write_register(REG_REPLACE_LENGTH, {60'd0, rlen});

    texts    = $urandom_range(2, 5);
    open_end = ($urandom_range(0, 4) == 0);
    for (t = 0; t < texts; t++) begin
      words.delete();
      goal = $urandom_range(1, 16);
      while (words.size() < goal) begin
        pick = $urandom_range(0, 99);
        if (span > 0 && pick < 40) begin
          for (i = 0; i < span; i++) words.push_back(pat[8 * i +: 8]);
        end else if (span > 0 && pick < 65) begin
          cut = $urandom_range(1, span);
          for (i = 0; i < cut; i++) words.push_back(pat[8 * i +: 8]);
        end else if (pick < 90) begin
          words.push_back(sym[$urandom_range(0, 1)]);
        end else begin
          words.push_back(8'($urandom_range(0, 255)));
        end
      end
      // the last text of a phase may stay open across the next pattern write
      for (i = 0; i < words.size(); i++) begin
        send_text_word(words[i],
                       (i == words.size() - 1) && !(open_end && t == texts - 1),
                       1'b0, '0);
        random_words++;
      end
    end
  endtask

  // ---------------- result checker ----------------

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_ready) begin
      if (rewrite_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual byte %h present %b last %b",
                 $time, result_byte, byte_present, result_last);
        error_count++;
      end else begin
        head = rewrite_q.pop_front();
        if (result_byte !== head.result_byte) begin
          $display("%0t: result_byte expected %h actual %h",
                   $time, head.result_byte, result_byte);
          error_count++;
        end
        if (byte_present !== head.byte_present) begin
          $display("%0t: byte_present expected %b actual %b",
                   $time, head.byte_present, byte_present);
          error_count++;
        end
        if (result_last !== head.result_last) begin
          $display("%0t: result_last expected %b actual %b",
                   $time, head.result_last, result_last);
          error_count++;
        end
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    int ph;
    rebuild_borders();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        settle_block();
        write_register(dir_rows[r].reg_idx, dir_rows[r].value);
      end else begin
        send_text_word(dir_rows[r].value[7:0], dir_rows[r].text_last,
                       dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // random phases
    ph = 0;
    while (random_words < RANDOM_WORDS) begin
      run_random_phase(ph);
      ph++;
    end

    settle_block();
    if (error_count == 0) begin
      $display("** stream_substring_replace: PASSED **");
    end else begin
      $display("** stream_substring_replace: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("** stream_substring_replace: FAILED **");
    $finish;
  end

endmodule
